[rtl/core/apds_pkg.sv]
// Shared types and constants of the ADC packet deframer and scaler.
package apds_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CH_W   = 4;
  localparam int unsigned VOLT_W = 27;

  localparam logic [BYTE_W-1:0] TERM_FF = 8'hFF;
  localparam logic [BYTE_W-1:0] TERM_00 = 8'h00;

  localparam int unsigned RANGE_BIT = 14;

  localparam logic signed [16:0] ZERO_CODE   = 17'sd2048;
  localparam logic signed [10:0] GAIN_X10    = 11'sd101;
  localparam logic signed [10:0] GAIN_DIRECT = 11'sd1010;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic shift;    // shift the received byte into the window
    logic load;     // capture the sample words of a matching window
    logic advance;  // move on to the next channel
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;    // window holds a terminated packet with a good checksum
    logic last;     // current channel is the final one of the packet
  } status_t;

endpackage

[rtl/core/adc_packet_deframer_scaler_core.sv]
// Top level of the ADC packet deframer and scaler.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   rx      | in        | rx_valid_i/rx_ready_o   | rx_byte_i
//   res     | out       | res_valid_o/res_ready_i | channel_index_o, raw_code_o, range_x10_o,
//           |           |                        | voltage_fixed_o, last_of_packet_o
//
// A byte that does not complete a packet leaves rx ready for the next byte.
// The cycle after a byte that completes a packet, the samples are captured and rx is
// held off while NUM_CHANNELS results leave, one per cycle while res_ready_i is high.
// Reset clears the byte window and its running checksum to zero; an all-zero window
// carries no terminator, so nothing is emitted until a full packet has arrived.
module adc_packet_deframer_scaler_core #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   rx_valid_i,
  output logic                                   rx_ready_o,
  input  logic [apds_pkg::BYTE_W-1:0]            rx_byte_i,
  output logic                                   res_valid_o,
  input  logic                                   res_ready_i,
  output logic [apds_pkg::CH_W-1:0]              channel_index_o,
  output logic [apds_pkg::WORD_W-1:0]            raw_code_o,
  output logic                                   range_x10_o,
  output logic signed [apds_pkg::VOLT_W-1:0]     voltage_fixed_o,
  output logic                                   last_of_packet_o
);

  apds_pkg::cmd_t    cmd;
  apds_pkg::status_t status;

  // Sequence: accept bytes, start on each fresh matching window once, drain the channels.
  apds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the window and running sum, capture samples, scale the current channel.
  apds_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .channel_index_o  (channel_index_o),
    .raw_code_o       (raw_code_o),
    .range_x10_o      (range_x10_o),
    .voltage_fixed_o  (voltage_fixed_o),
    .last_of_packet_o (last_of_packet_o)
  );

endmodule

[rtl/core/apds_ctrl.sv]
// Controller state machine of the ADC packet deframer and scaler.
module apds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  input  apds_pkg::status_t status_i,
  output apds_pkg::cmd_t    cmd_o
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EMIT = 1'b1;

  logic [0:0] state_q, state_d;
  logic       pending_q, pending_d;
  logic       start;

  // A window starts a packet at most once, right after the byte that formed it.
  assign start = (state_q == ST_IDLE) && pending_q && status_i.match;

  always_comb begin
    state_d        = state_q;
    pending_d      = pending_q;
    rx_ready_o     = 1'b0;
    res_valid_o    = 1'b0;
    cmd_o.shift    = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.advance  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        rx_ready_o = !start;
        if (start) begin
          cmd_o.load = 1'b1;
          pending_d  = 1'b0;
          state_d    = ST_EMIT;
        end else if (rx_valid_i) begin
          cmd_o.shift = 1'b1;
          pending_d   = 1'b1;
        end
      end
      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          cmd_o.advance = 1'b1;
          if (status_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

endmodule

[rtl/core/apds_datapath.sv]
// Byte window, running checksum, sample capture and voltage scaling.
module apds_datapath #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [apds_pkg::BYTE_W-1:0]            rx_byte_i,
  input  apds_pkg::cmd_t                         cmd_i,
  output apds_pkg::status_t                      status_o,
  output logic [apds_pkg::CH_W-1:0]              channel_index_o,
  output logic [apds_pkg::WORD_W-1:0]            raw_code_o,
  output logic                                   range_x10_o,
  output logic signed [apds_pkg::VOLT_W-1:0]     voltage_fixed_o,
  output logic                                   last_of_packet_o
);

  localparam int unsigned WIN_LEN  = 2 * NUM_CHANNELS + 6;
  localparam int unsigned SUM_LEN  = 2 * NUM_CHANNELS + 2;
  localparam int unsigned CK_POS   = 2 * NUM_CHANNELS + 2;
  localparam int unsigned TERM_POS = 2 * NUM_CHANNELS + 3;

  logic [apds_pkg::BYTE_W-1:0] win_q [WIN_LEN];
  logic [apds_pkg::BYTE_W-1:0] sum_q;
  logic [apds_pkg::WORD_W-1:0] words_q [NUM_CHANNELS];
  logic [apds_pkg::CH_W-1:0]   ch_q;

  logic [apds_pkg::WORD_W-1:0] code;
  logic signed [16:0]          centered;
  logic signed [10:0]          gain;
  logic signed [27:0]          product;

  // Window and sum of its oldest bytes: drop the oldest, add the one that slides in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WIN_LEN-1] <= rx_byte_i;
      sum_q <= sum_q - win_q[0] + win_q[SUM_LEN];
    end
  end

  assign status_o.match = (win_q[TERM_POS]   == apds_pkg::TERM_FF) &&
                          (win_q[TERM_POS+1] == apds_pkg::TERM_00) &&
                          (win_q[TERM_POS+2] == apds_pkg::TERM_FF) &&
                          (sum_q == win_q[CK_POS]);
  assign status_o.last  = (ch_q == apds_pkg::CH_W'(NUM_CHANNELS - 1));

  // Captured samples drain from the bottom, one channel per transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        words_q[k] <= {win_q[2*k+1], win_q[2*k]};
      end
    end else if (cmd_i.advance) begin
      for (int k = 0; k < NUM_CHANNELS - 1; k++) begin
        words_q[k] <= words_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (cmd_i.load) begin
      ch_q <= '0;
    end else if (cmd_i.advance) begin
      ch_q <= ch_q + apds_pkg::CH_W'(1);
    end
  end

  always_comb begin
    code                      = words_q[0];
    code[apds_pkg::RANGE_BIT] = 1'b0;
  end

  assign range_x10_o = words_q[0][apds_pkg::RANGE_BIT];
  assign centered    = signed'({1'b0, code}) - apds_pkg::ZERO_CODE;
  assign gain        = range_x10_o ? apds_pkg::GAIN_X10 : apds_pkg::GAIN_DIRECT;
  assign product     = centered * gain;

  assign channel_index_o  = ch_q;
  assign raw_code_o       = words_q[0];
  assign voltage_fixed_o  = product[apds_pkg::VOLT_W-1:0];
  assign last_of_packet_o = status_o.last;

endmodule

[rtl/core/apds_checker.sv]
// Port-level checker of the ADC packet deframer and scaler, with its bind.
module apds_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               rx_ready_o,
  input logic                               res_valid_o,
  input logic                               res_ready_i,
  input logic [apds_pkg::CH_W-1:0]          channel_index_o,
  input logic [apds_pkg::WORD_W-1:0]        raw_code_o,
  input logic                               last_of_packet_o
);

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(raw_code_o)
      && $stable(channel_index_o))
    else $error("stalled result changed");

  // No byte is taken while a packet drains.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rx_ready_o && res_valid_o))
    else $error("input ready while results pending");

  // A packet starts at channel zero.
  a_first_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> channel_index_o == '0)
    else $error("packet did not start at channel zero");

  // Channels follow in order with no gap.
  a_next_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && !last_of_packet_o |=>
      res_valid_o && channel_index_o == $past(channel_index_o) + apds_pkg::CH_W'(1))
    else $error("channel sequence broken");

  // The final transfer ends the packet.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && last_of_packet_o |=> !res_valid_o)
    else $error("results continued past last channel");

endmodule

bind adc_packet_deframer_scaler_core apds_checker u_apds_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_ready_o       (rx_ready_o),
  .res_valid_o      (res_valid_o),
  .res_ready_i      (res_ready_i),
  .channel_index_o  (channel_index_o),
  .raw_code_o       (raw_code_o),
  .last_of_packet_o (last_of_packet_o)
);
